// ----- hdl/b32ce_pkg.sv -----
// Shared types, constants and checksum functions of the Bech32 checksum encoder.
`timescale 1ns / 1ps

package b32ce_pkg;

    localparam int PREFIX_MAX = 16;
    localparam int CNT_W      = $clog2(PREFIX_MAX + 1);
    localparam int ADDR_W     = (PREFIX_MAX > 1) ? $clog2(PREFIX_MAX) : 1;
    localparam int FIN_STEPS  = 6;

    localparam logic [1:0] FUNC_PREFIX = 2'd0;
    localparam logic [1:0] FUNC_DATA   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [29:0] ACC_INIT = 30'd1;
    localparam logic [7:0]  SEP_CHAR = 8'h31;

    localparam logic [29:0] GEN_POLY [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_EMIT_SEP,
        ST_EMIT_SYM,
        ST_FIN_FOLD,
        ST_FIN_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PREFIX,
        OP_PREFIX_ERR,
        OP_ERROR,
        OP_DATA,
        OP_SEP_START,
        OP_FLUSH,
        OP_EMIT_SEP,
        OP_EMIT_SYM,
        OP_FIN_FOLD,
        OP_FIN_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic prefix_err;
        logic data_err;
        logic sep_done;
        logic idx_done;
        logic cnt_last;
        logic out_free;
    } dp_status_t;

    // One polymod step: shift in a 5-bit symbol and reduce by the generator.
    function automatic logic [29:0] b32_fold(input logic [29:0] chk, input logic [4:0] v);
        logic [29:0] r;
        r = {chk[24:0], 5'b00000} ^ {25'b0, v};
        for (int i = 0; i < 5; i++) begin
            if (chk[25 + i]) begin
                r = r ^ GEN_POLY[i];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] b32_char(input logic [4:0] sym);
        return CHARSET[8 * (31 - int'(sym)) +: 8];
    endfunction

endpackage

// ----- hdl/b32ce_ctrl.sv -----
// Controller state machine of the Bech32 checksum encoder.
`timescale 1ns / 1ps

module b32ce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [1:0]            s_func,
    output logic                  s_ready,
    input  b32ce_pkg::dp_status_t status,
    output b32ce_pkg::dp_cmd_t    cmd
);
    import b32ce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = status.out_free;
                if (s_valid && status.out_free) begin
                    priority case (s_func)
                        FUNC_PREFIX: begin
                            cmd.op = status.prefix_err ? OP_PREFIX_ERR : OP_PREFIX;
                        end
                        FUNC_DATA: begin
                            if (status.data_err) begin
                                cmd.op = OP_ERROR;
                            end else if (status.sep_done) begin
                                cmd.op = OP_DATA;
                            end else begin
                                // First data symbol: flush the stored prefix low parts.
                                cmd.op     = OP_SEP_START;
                                state_next = ST_FLUSH;
                            end
                        end
                        FUNC_FINISH: begin
                            if (!status.sep_done) begin
                                cmd.op = OP_ERROR;
                            end else begin
                                cmd.op     = OP_FIN_FOLD;
                                state_next = ST_FIN_FOLD;
                            end
                        end
                        default: begin
                            cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (status.idx_done) begin
                    state_next = ST_EMIT_SEP;
                end else begin
                    cmd.op = OP_FLUSH;
                end
            end
            ST_EMIT_SEP: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT_SEP;
                    state_next = ST_EMIT_SYM;
                end
            end
            ST_EMIT_SYM: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT_SYM;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_FOLD: begin
                cmd.op = OP_FIN_FOLD;
                if (status.cnt_last) begin
                    state_next = ST_FIN_EMIT;
                end
            end
            ST_FIN_EMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_FIN_EMIT;
                    if (status.cnt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/b32ce_datapath.sv -----
// Datapath of the Bech32 checksum encoder: polymod, prefix store and output register.
`timescale 1ns / 1ps

module b32ce_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  b32ce_pkg::dp_cmd_t    cmd,
    output b32ce_pkg::dp_status_t status,
    input  logic [7:0]            s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic                  m_last,
    output logic                  m_error
);
    import b32ce_pkg::*;

    logic [29:0]      acc_reg, acc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sep_done_reg, sep_done_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [4:0]       sym_reg, sym_next;
    logic [4:0]       rd_data_reg;
    logic [4:0]       prefix_mem [PREFIX_MAX];
    logic             mem_we;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;
    logic             out_error_reg;
    logic             out_load;
    logic [7:0]       out_char_next;
    logic             out_last_next;
    logic             out_error_next;

    logic             cnt_last;

    assign cnt_last = (cnt_reg == 3'(FIN_STEPS - 1));

    assign status.prefix_err = sep_done_reg || (count_reg == CNT_W'(PREFIX_MAX));
    assign status.data_err   = (s_value[7:5] != 3'b000);
    assign status.sep_done   = sep_done_reg;
    assign status.idx_done   = (idx_reg == count_reg);
    assign status.cnt_last   = cnt_last;
    assign status.out_free   = !out_valid_reg || m_ready;

    always_comb begin
        acc_next       = acc_reg;
        count_next     = count_reg;
        sep_done_next  = sep_done_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        sym_next       = sym_reg;
        mem_we         = 1'b0;
        out_load       = 1'b0;
        out_char_next  = 8'h00;
        out_last_next  = 1'b0;
        out_error_next = 1'b0;
        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_PREFIX: begin
                acc_next      = b32_fold(acc_reg, {2'b00, s_value[7:5]});
                mem_we        = 1'b1;
                count_next    = count_reg + CNT_W'(1);
                out_load      = 1'b1;
                out_char_next = s_value;
            end
            OP_PREFIX_ERR: begin
                out_load       = 1'b1;
                out_char_next  = s_value;
                out_error_next = 1'b1;
            end
            OP_ERROR: begin
                out_load       = 1'b1;
                out_error_next = 1'b1;
            end
            OP_DATA: begin
                acc_next      = b32_fold(acc_reg, s_value[4:0]);
                out_load      = 1'b1;
                out_char_next = b32_char(s_value[4:0]);
            end
            OP_SEP_START: begin
                acc_next = b32_fold(acc_reg, 5'd0);
                idx_next = '0;
                sym_next = s_value[4:0];
            end
            OP_FLUSH: begin
                acc_next = b32_fold(acc_reg, rd_data_reg);
                idx_next = idx_reg + CNT_W'(1);
            end
            OP_EMIT_SEP: begin
                out_load      = 1'b1;
                out_char_next = SEP_CHAR;
            end
            OP_EMIT_SYM: begin
                acc_next      = b32_fold(acc_reg, sym_reg);
                sep_done_next = 1'b1;
                out_load      = 1'b1;
                out_char_next = b32_char(sym_reg);
            end
            OP_FIN_FOLD: begin
                // The final constant 1 is XORed in on the sixth zero fold.
                acc_next = b32_fold(acc_reg, 5'd0) ^ {29'd0, cnt_last};
                cnt_next = cnt_last ? 3'd0 : cnt_reg + 3'd1;
            end
            OP_FIN_EMIT: begin
                out_load      = 1'b1;
                out_char_next = b32_char(acc_reg[29:25]);
                out_last_next = cnt_last;
                acc_next      = {acc_reg[24:0], 5'b00000};
                cnt_next      = cnt_reg + 3'd1;
                if (cnt_last) begin
                    acc_next      = ACC_INIT;
                    count_next    = '0;
                    sep_done_next = 1'b0;
                    cnt_next      = 3'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= ACC_INIT;
            count_reg     <= '0;
            sep_done_reg  <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg      <= acc_next;
            count_reg    <= count_next;
            sep_done_reg <= sep_done_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
        if (out_load) begin
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_error_reg <= out_error_next;
        end
    end

    // Prefix store; the read address runs one entry ahead of the flush fold.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            prefix_mem[count_reg[ADDR_W-1:0]] <= s_value[4:0];
        end
        rd_data_reg <= prefix_mem[idx_next[ADDR_W-1:0]];
    end

    assign m_valid    = out_valid_reg;
    assign m_out_char = out_char_reg;
    assign m_last     = out_last_reg;
    assign m_error    = out_error_reg;

endmodule

// ----- hdl/bech32_checksum_encoder_top.sv -----
// Top level of the Bech32 checksum encoder: controller and datapath.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  s_      | s_valid s_ready s_func[1:0] s_value[7:0]     | input
//  m_      | m_valid m_ready m_out_char[7:0] m_last m_error | output
//
// A prefix character, a later data symbol or a rejected item is handled in the idle state alone.
// The first data symbol folds a zero at its transfer, then one stored prefix part
// per cycle through the prefix store read port, leaves the flush in a step with no
// fold, then makes two output transfers ('1' and the symbol).
// Finish makes six zero polymod folds, then six output transfers.
// Reset sets the polymod to 1 and clears the prefix count and the separator flag at once.
// A stalled output register holds the emit states; s_ready drops until it frees.
`timescale 1ns / 1ps

module bech32_checksum_encoder_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last,
    output logic       m_error
);
    import b32ce_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    b32ce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    b32ce_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last),
        .m_error    (m_error)
    );

    // An input transfer is only taken when the output register can take a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("input taken while output register is blocked");

    // The last checksum character never carries the error flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> !m_error)
        else $error("last character flagged as error");

    // A stalled result holds its valid and payload until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_char)
                                   && $stable(m_last) && $stable(m_error)))
        else $error("stalled result changed before its transfer");

endmodule
